/* design/vpa_pkg.sv */
// Package: constants, codes and types shared by the partition allocator
`default_nettype none
package vpa_pkg;
    localparam int MAP_ENTRIES = 16;
    localparam int ADDR_BITS   = 16;
    localparam int IDX_BITS    = $clog2(MAP_ENTRIES);
    localparam int CNT_BITS    = $clog2(MAP_ENTRIES + 1);
    localparam int SIZE_BITS   = ADDR_BITS + 1;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] POL_NEXT  = 2'd3;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOOWNER = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] blk_start;
        logic [15:0] blk_end;
        logic [16:0] blk_size;
        logic [7:0]  blk_owner;
    } vpa_result_t;

    typedef struct packed {
        logic           load;     // capture command
        logic           scan;     // examine the current scan entry
        logic           decide;   // resolve scan, prepare edit
        logic           shift_up; // insert shift step
        logic           split;    // final split write
        logic           shift_dn; // remove shift step
        logic           merge;    // merge write
        logic           clear_own;
        logic           emit;     // write result register
    } vpa_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic is_alloc;
        logic found;
        logic exact;
        logic full;
        logic shift_up_done;
        logic shift_dn_done;
        logic merge_needed;
    } vpa_stat_t;
endpackage
`default_nettype wire

/* design/vpa_if.sv */
// Interfaces: command, result and configuration channels
`default_nettype none
interface vpa_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] req_size;
    logic [7:0]  owner_id;
    logic [15:0] search_from;
    modport source (output valid, cmd, req_size, owner_id, search_from, input ready);
    modport sink   (input valid, cmd, req_size, owner_id, search_from, output ready);
endinterface

interface vpa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] blk_start;
    logic [15:0] blk_end;
    logic [16:0] blk_size;
    logic [7:0]  blk_owner;
    modport source (output valid, status, blk_start, blk_end, blk_size, blk_owner,
                    input ready);
    modport sink   (input valid, status, blk_start, blk_end, blk_size, blk_owner,
                    output ready);
endinterface

interface vpa_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

/* design/variable_partition_allocator.sv */
// Top level: variable partition allocator over an ordered segment table
// Usage:
//  req channel carries one command per transfer: allocate (cmd 0) with size,
//  owner and next-fit start address, or release (cmd 1) of an owner's segment.
//  rsp channel returns one result per command: status and allocated segment.
//  cfg channel writes the fit policy (first, best, worst, next); write it only
//  while no command is in flight.
// Timing:
//  A command scans the table one entry per cycle, then a split shifts
//  entries up one per cycle and a merge shifts entries down one per cycle;
//  one command in flight at a time.
// Reset:
//  The table holds one free segment covering the whole address space and the
//  policy is first fit.
// Stall:
//  The result waits in an output register; the next command is accepted and
//  worked, and its result waits until the earlier one is taken.
`default_nettype none
module variable_partition_allocator
    import vpa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    vpa_req_if.sink  req,
    vpa_rsp_if.source rsp,
    vpa_cfg_if.sink  cfg
);
    vpa_cmd_t    ctl;
    vpa_stat_t   sts;
    vpa_result_t res;
    logic [1:0]  policy_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
        end
        else if (cfg.valid)
        begin
            policy_reg <= cfg.data;
        end
    end

    vpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    vpa_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .policy         (policy_reg),
        .in_cmd         (req.cmd),
        .in_req_size    (req.req_size),
        .in_owner_id    (req.owner_id),
        .in_search_from (req.search_from),
        .result         (res)
    );

    assign rsp.status    = res.status;
    assign rsp.blk_start = res.blk_start;
    assign rsp.blk_end   = res.blk_end;
    assign rsp.blk_size  = res.blk_size;
    assign rsp.blk_owner = res.blk_owner;
endmodule
`default_nettype wire

/* design/vpa_datapath.sv */
// Datapath: segment table, scan unit, shift/split/merge edits, result register
`default_nettype none
module vpa_datapath
    import vpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire vpa_cmd_t    ctl,
    output vpa_stat_t        sts,
    input  wire logic [1:0]  policy,
    input  wire logic        in_cmd,
    input  wire logic [15:0] in_req_size,
    input  wire logic [7:0]  in_owner_id,
    input  wire logic [15:0] in_search_from,
    output vpa_result_t      result
);
    logic [ADDR_BITS-1:0] start_reg [MAP_ENTRIES];
    logic [ADDR_BITS-1:0] end_reg   [MAP_ENTRIES];
    logic [SIZE_BITS-1:0] size_reg  [MAP_ENTRIES];
    logic [7:0]           owner_reg [MAP_ENTRIES];
    logic [CNT_BITS-1:0]  count_reg;

    logic                 op_reg;
    logic [15:0]          req_reg;
    logic [7:0]           own_reg;
    logic [15:0]          from_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic                 done_reg;
    logic                 found_reg;
    logic [IDX_BITS-1:0]  pick_reg;
    logic [SIZE_BITS-1:0] best_reg;
    logic [CNT_BITS-1:0]  ptr_reg;
    logic                 left_reg, right_reg;
    vpa_result_t          result_reg;

    logic [SIZE_BITS-1:0] req_ext, left_amt;
    logic                 cand, take;
    logic [CNT_BITS-1:0]  idx_ext, pick_ext;
    logic [IDX_BITS-1:0]  ptr_idx, pm1, pp1, rm_pos;
    logic [1:0]           rm_n;

    assign req_ext  = SIZE_BITS'(req_reg);
    assign left_amt = size_reg[idx_reg] - req_ext;
    assign idx_ext  = CNT_BITS'(idx_reg);
    assign pick_ext = CNT_BITS'(pick_reg);
    assign ptr_idx  = ptr_reg[IDX_BITS-1:0];
    assign pm1      = pick_reg - 1'b1;
    assign pp1      = pick_reg + 1'b1;
    assign rm_n     = (left_reg && right_reg) ? 2'd2 : 2'd1;
    assign rm_pos   = left_reg ? pick_reg : pp1;

    always_comb
    begin
        cand = 1'b0;
        take = 1'b0;
        if (op_reg == CMD_ALLOC)
        begin
            cand = (owner_reg[idx_reg] == 8'd0) && (size_reg[idx_reg] >= req_ext)
                   && (req_reg != 16'd0) && (own_reg != 8'd0);
            case (policy)
                POL_FIRST: take = cand && !found_reg;
                POL_NEXT:  take = cand && !found_reg && (start_reg[idx_reg] >= from_reg);
                POL_BEST:  take = cand && (!found_reg || left_amt < best_reg);
                POL_WORST: take = cand && (!found_reg || left_amt > best_reg);
                default:   take = 1'b0;
            endcase
        end
        else
        begin
            take = (own_reg != 8'd0) && (owner_reg[idx_reg] == own_reg) && !found_reg;
        end
    end

    always_comb
    begin
        sts.scan_last     = done_reg || (idx_ext + 1'b1 >= count_reg)
                            || (idx_reg == IDX_BITS'(MAP_ENTRIES - 1));
        sts.is_alloc      = (op_reg == CMD_ALLOC);
        sts.found         = found_reg;
        sts.exact         = size_reg[pick_reg] == req_ext;
        sts.full          = count_reg >= CNT_BITS'(MAP_ENTRIES);
        sts.shift_up_done = ptr_reg <= pick_ext;
        sts.shift_dn_done = ptr_reg + CNT_BITS'(rm_n) >= count_reg;
        sts.merge_needed  = left_reg || right_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_BITS'(1);
            for (int i = 0; i < MAP_ENTRIES; i++)
            begin
                owner_reg[i] <= 8'd0;
            end
            start_reg[0] <= '0;
            end_reg[0]   <= '1;
            size_reg[0]  <= SIZE_BITS'(1) << ADDR_BITS;
        end
        else
        begin
            if (ctl.shift_up)
            begin
                start_reg[ptr_idx] <= start_reg[ptr_idx - 1'b1];
                end_reg[ptr_idx]   <= end_reg[ptr_idx - 1'b1];
                size_reg[ptr_idx]  <= size_reg[ptr_idx - 1'b1];
                owner_reg[ptr_idx] <= owner_reg[ptr_idx - 1'b1];
            end
            if (ctl.split)
            begin
                end_reg[pick_reg]   <= start_reg[pick_reg] + ADDR_BITS'(req_reg) - 1'b1;
                size_reg[pick_reg]  <= req_ext;
                owner_reg[pick_reg] <= own_reg;
                start_reg[pp1]      <= start_reg[pp1] + ADDR_BITS'(req_reg);
                size_reg[pp1]       <= size_reg[pp1] - req_ext;
                count_reg           <= count_reg + 1'b1;
            end
            if (ctl.clear_own)
            begin
                owner_reg[pick_reg] <= sts.exact && sts.is_alloc ? own_reg : 8'd0;
            end
            if (ctl.merge)
            begin
                if (left_reg && right_reg)
                begin
                    end_reg[pm1]  <= end_reg[pp1];
                    size_reg[pm1] <= size_reg[pm1] + size_reg[pick_reg] + size_reg[pp1];
                end
                else if (left_reg)
                begin
                    end_reg[pm1]  <= end_reg[pick_reg];
                    size_reg[pm1] <= size_reg[pm1] + size_reg[pick_reg];
                end
                else
                begin
                    end_reg[pick_reg]   <= end_reg[pp1];
                    size_reg[pick_reg]  <= size_reg[pick_reg] + size_reg[pp1];
                    owner_reg[pick_reg] <= 8'd0;
                end
            end
            if (ctl.shift_dn)
            begin
                if (ptr_reg + CNT_BITS'(rm_n) < count_reg)
                begin
                    start_reg[ptr_idx] <= start_reg[ptr_idx + IDX_BITS'(rm_n)];
                    end_reg[ptr_idx]   <= end_reg[ptr_idx + IDX_BITS'(rm_n)];
                    size_reg[ptr_idx]  <= size_reg[ptr_idx + IDX_BITS'(rm_n)];
                    owner_reg[ptr_idx] <= owner_reg[ptr_idx + IDX_BITS'(rm_n)];
                end
                else
                begin
                    count_reg <= count_reg - CNT_BITS'(rm_n);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg    <= in_cmd;
            req_reg   <= in_req_size;
            own_reg   <= in_owner_id;
            from_reg  <= in_search_from;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pick_reg  <= '0;
            best_reg  <= '0;
        end
        if (ctl.scan)
        begin
            if (take)
            begin
                found_reg <= 1'b1;
                pick_reg  <= idx_reg;
                best_reg  <= left_amt;
                if (op_reg == CMD_RELEASE || policy == POL_FIRST || policy == POL_NEXT)
                begin
                    done_reg <= 1'b1;
                end
            end
            if (!sts.scan_last)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (ctl.decide)
        begin
            ptr_reg   <= count_reg;
            left_reg  <= (pick_reg != '0) && (owner_reg[pm1] == 8'd0);
            right_reg <= (CNT_BITS'(pp1) < count_reg) && (pick_ext + 1'b1 < count_reg)
                         && (owner_reg[pp1] == 8'd0);
        end
        if (ctl.shift_up)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        if (ctl.merge)
        begin
            ptr_reg <= CNT_BITS'(rm_pos);
        end
        if (ctl.shift_dn)
        begin
            ptr_reg <= ptr_reg + 1'b1;
        end
        if (ctl.emit)
        begin
            result_reg <= '0;
            if (op_reg == CMD_RELEASE)
            begin
                result_reg.status <= found_reg ? ST_OK : ST_NOOWNER;
            end
            else if (!found_reg)
            begin
                result_reg.status <= ST_NOFIT;
            end
            else if (!sts.exact && count_reg >= CNT_BITS'(MAP_ENTRIES)
                     && !(ptr_reg != count_reg))
            begin
                result_reg.status <= ST_FULL;
            end
            else
            begin
                result_reg.status    <= ST_OK;
                result_reg.blk_start <= 16'(start_reg[pick_reg]);
                result_reg.blk_end   <= 16'(end_reg[pick_reg]);
                result_reg.blk_size  <= 17'(size_reg[pick_reg]);
                result_reg.blk_owner <= owner_reg[pick_reg];
            end
        end
    end

    assign result = result_reg;

`ifndef SYNTHESIS
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0) else $error("segment count zero");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAP_ENTRIES)) else $error("segment count overflow");
    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.split |-> count_reg < CNT_BITS'(MAP_ENTRIES)) else $error("split on full table");
`endif
endmodule
`default_nettype wire

/* design/vpa_ctrl.sv */
// Controller: sequences scan, insert/remove shifts and result delivery
`default_nettype none
module vpa_ctrl
    import vpa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire vpa_stat_t sts,
    output vpa_cmd_t       ctl
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SHUP   = 9'b000001000,
        S_SPLIT  = 9'b000010000,
        S_MERGE  = 9'b000100000,
        S_SHDN   = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_HOLD   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   ok_alloc_split;

    assign ok_alloc_split = sts.is_alloc && sts.found && !sts.exact && !sts.full;

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        ctl         = '0;
        in_ready    = 1'b0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.decide = 1'b1;
                if (ok_alloc_split)
                begin
                    state_next = S_SHUP;
                end
                else if (sts.found)
                begin
                    state_next = S_MERGE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_SHUP:
            begin
                if (sts.shift_up_done)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    ctl.shift_up = 1'b1;
                end
            end
            S_SPLIT:
            begin
                ctl.split  = 1'b1;
                state_next = S_EMIT;
            end
            S_MERGE:
            begin
                if (sts.is_alloc)
                begin
                    if (sts.exact)
                    begin
                        ctl.clear_own = 1'b1;
                    end
                    state_next = S_EMIT;
                end
                else if (sts.merge_needed)
                begin
                    ctl.merge  = 1'b1;
                    state_next = S_SHDN;
                end
                else
                begin
                    ctl.clear_own = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_SHDN:
            begin
                ctl.shift_dn = 1'b1;
                if (sts.shift_dn_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_next)
                begin
                    ctl.emit    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.emit |-> (!ovalid_reg || out_ready)) else $error("result overwritten");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_SCAN) else $error("load did not start scan");
`endif
endmodule
`default_nettype wire

/* verif/vpa_tb_if.sv */
// Testbench-side interface bundle: none needed beyond design interfaces; holds shared tb types
package vpa_tb_pkg;
    import vpa_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] blk_start;
        logic [15:0] blk_end;
        logic [16:0] blk_size;
        logic [7:0]  blk_owner;
    } alloc_outcome_t;
endpackage

/* verif/vpa_checker.sv */
// Checker: models the segment table, predicts each result and compares transfers
module vpa_checker
    import vpa_pkg::*;
    import vpa_tb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    vpa_req_if.sink   req,
    vpa_rsp_if.sink   rsp,
    vpa_cfg_if.sink   cfg,
    output int        errors,
    output int        pending,
    output int        results_seen
);
    logic [15:0] tbl_start [MAP_ENTRIES+1];
    logic [15:0] tbl_end   [MAP_ENTRIES+1];
    logic [16:0] tbl_size  [MAP_ENTRIES+1];
    logic [7:0]  tbl_owner [MAP_ENTRIES+1];
    int          tbl_count;
    logic [1:0]  policy;
    alloc_outcome_t outcome_q[$];

    function automatic alloc_outcome_t fail_outcome(logic [1:0] st);
        alloc_outcome_t o;
        o.status = st;
        o.blk_start = '0;
        o.blk_end = '0;
        o.blk_size = '0;
        o.blk_owner = '0;
        return o;
    endfunction

    function automatic alloc_outcome_t entry_outcome(int k);
        alloc_outcome_t o;
        o.status = ST_OK;
        o.blk_start = tbl_start[k];
        o.blk_end = tbl_end[k];
        o.blk_size = tbl_size[k];
        o.blk_owner = tbl_owner[k];
        return o;
    endfunction

    task automatic drop_entries(int pos, int n);
        for (int k = pos; k + n < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k+n];
            tbl_end[k] = tbl_end[k+n];
            tbl_size[k] = tbl_size[k+n];
            tbl_owner[k] = tbl_owner[k+n];
        end
        tbl_count -= n;
    endtask

    task automatic predict_allocate(logic [15:0] want, logic [7:0] who, logic [15:0] from);
        bit          hit;
        int          pick;
        logic [16:0] left;
        logic [16:0] best;
        hit = 0;
        pick = 0;
        best = '0;
        if (want == 0 || who == 0)
        begin
            outcome_q.push_back(fail_outcome(ST_NOFIT));
            return;
        end
        for (int k = 0; k < tbl_count; k++)
        begin
            if (tbl_owner[k] != 0 || tbl_size[k] < {1'b0, want})
                continue;
            left = tbl_size[k] - {1'b0, want};
            if (policy == POL_FIRST)
            begin
                hit = 1; pick = k; break;
            end
            else if (policy == POL_NEXT)
            begin
                if (tbl_start[k] >= from)
                begin
                    hit = 1; pick = k; break;
                end
            end
            else if (policy == POL_BEST)
            begin
                if (!hit || left < best)
                begin
                    hit = 1; pick = k; best = left;
                end
            end
            else if (!hit || left > best)
            begin
                hit = 1; pick = k; best = left;
            end
        end
        if (!hit)
        begin
            outcome_q.push_back(fail_outcome(ST_NOFIT));
            return;
        end
        if (tbl_size[pick] == {1'b0, want})
        begin
            tbl_owner[pick] = who;
            outcome_q.push_back(entry_outcome(pick));
            return;
        end
        if (tbl_count >= MAP_ENTRIES)
        begin
            outcome_q.push_back(fail_outcome(ST_FULL));
            return;
        end
        for (int k = tbl_count; k > pick; k--)
        begin
            tbl_start[k] = tbl_start[k-1];
            tbl_end[k] = tbl_end[k-1];
            tbl_size[k] = tbl_size[k-1];
            tbl_owner[k] = tbl_owner[k-1];
        end
        tbl_count++;
        tbl_end[pick] = tbl_start[pick] + want - 16'd1;
        tbl_size[pick] = {1'b0, want};
        tbl_owner[pick] = who;
        tbl_start[pick+1] = tbl_start[pick+1] + want;
        tbl_size[pick+1] = tbl_size[pick+1] - {1'b0, want};
        outcome_q.push_back(entry_outcome(pick));
    endtask

    task automatic predict_release(logic [7:0] who);
        int idx;
        bit lfree;
        bit rfree;
        idx = -1;
        if (who != 0)
            for (int k = 0; k < tbl_count; k++)
                if (tbl_owner[k] == who)
                begin
                    idx = k; break;
                end
        if (idx < 0)
        begin
            outcome_q.push_back(fail_outcome(ST_NOOWNER));
            return;
        end
        lfree = idx > 0 && tbl_owner[idx-1] == 0;
        rfree = idx + 1 < tbl_count && tbl_owner[idx+1] == 0;
        if (lfree && rfree)
        begin
            tbl_end[idx-1] = tbl_end[idx+1];
            tbl_size[idx-1] = tbl_size[idx-1] + tbl_size[idx] + tbl_size[idx+1];
            drop_entries(idx, 2);
        end
        else if (lfree)
        begin
            tbl_end[idx-1] = tbl_end[idx];
            tbl_size[idx-1] = tbl_size[idx-1] + tbl_size[idx];
            drop_entries(idx, 1);
        end
        else if (rfree)
        begin
            tbl_end[idx] = tbl_end[idx+1];
            tbl_size[idx] = tbl_size[idx] + tbl_size[idx+1];
            tbl_owner[idx] = '0;
            drop_entries(idx + 1, 1);
        end
        else
            tbl_owner[idx] = '0;
        outcome_q.push_back(fail_outcome(ST_OK));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alloc_outcome_t exp_o;
        if (!rst_n)
        begin
            policy = POL_FIRST;
            tbl_count = 1;
            tbl_start[0] = '0;
            tbl_end[0] = 16'hFFFF;
            tbl_size[0] = 17'h10000;
            tbl_owner[0] = '0;
            outcome_q.delete();
            errors = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                policy = cfg.data;
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer at %0t", $realtime);
                end
                else
                begin
                    exp_o = outcome_q.pop_front();
                    if (rsp.status !== exp_o.status || rsp.blk_start !== exp_o.blk_start
                        || rsp.blk_end !== exp_o.blk_end || rsp.blk_size !== exp_o.blk_size
                        || rsp.blk_owner !== exp_o.blk_owner)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp st=%0d %h-%h sz=%h own=%0d",
                                exp_o.status, exp_o.blk_start, exp_o.blk_end,
                                exp_o.blk_size, exp_o.blk_owner,
                                ", got st=%0d %h-%h sz=%h own=%0d",
                                rsp.status, rsp.blk_start, rsp.blk_end,
                                rsp.blk_size, rsp.blk_owner);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.cmd == CMD_ALLOC)
                    predict_allocate(req.req_size, req.owner_id, req.search_from);
                else
                    predict_release(req.owner_id);
            end
            pending = outcome_q.size();
        end
    end
endmodule

/* verif/testbench.sv */
// Testbench top: drives commands, policy writes and stalls; reports the verdict
module testbench;
    import vpa_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   results_seen;
    int   cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_off;
    int   policy_writes;

    vpa_req_if req();
    vpa_rsp_if rsp();
    vpa_cfg_if cfg();

    variable_partition_allocator uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg));
    vpa_checker chk (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp), .cfg(cfg),
        .errors(errors), .pending(pending), .results_seen(results_seen));

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver side: random stall plus an optional long hold-off
    initial
    begin
        rsp.ready = 0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays high after a transfer unless the sender idles next
    task automatic send_cmd(logic c, logic [15:0] sz, logic [7:0] who, logic [15:0] from);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.cmd <= c;
        req.req_size <= sz;
        req.owner_id <= who;
        req.search_from <= from;
        do
            @(posedge clk);
        while (!req.ready);
    endtask

    task automatic write_policy(logic [1:0] p);
        req.valid <= 0;
        repeat (2 * MAP_ENTRIES + 10) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg.valid <= 1;
        cfg.data <= p;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 0;
        policy_writes++;
    endtask

    task automatic random_cmd();
        logic [15:0] sz;
        int          r;
        r = $urandom_range(99);
        case ($urandom_range(9))
            0: sz = 16'($urandom);
            1: sz = 16'(16'hFFFF - $urandom_range(3));
            2: sz = 16'($urandom_range(3));
            default: sz = 16'($urandom_range(1, 4096));
        endcase
        if (r < 55)
            send_cmd(CMD_ALLOC, sz, (r < 2) ? 8'd0 : 8'($urandom_range(1, 24)), 16'($urandom));
        else if (r < 95)
            send_cmd(CMD_RELEASE, 16'($urandom), 8'($urandom_range(1, 24)), 16'($urandom));
        else
            send_cmd(1'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
    endtask

    initial
    begin
        req.valid = 0;
        req.cmd = 0;
        req.req_size = 0;
        req.owner_id = 0;
        req.search_from = 0;
        cfg.valid = 0;
        cfg.data = 0;
        hold_off = 0;
        policy_writes = 0;
        send_idle_pct = 15;
        recv_idle_pct = 87;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: edges, zero size/owner, whole memory, unknown owner, full table
        send_cmd(CMD_ALLOC, 16'd0, 8'd5, 16'd0);
        send_cmd(CMD_ALLOC, 16'd10, 8'd0, 16'd0);
        send_cmd(CMD_RELEASE, 16'd0, 8'd0, 16'd0);
        send_cmd(CMD_RELEASE, 16'd0, 8'd77, 16'd0);
        send_cmd(CMD_ALLOC, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_cmd(CMD_ALLOC, 16'd1, 8'd2, 16'd0);
        send_cmd(CMD_ALLOC, 16'hFFFF, 8'd3, 16'd0);
        send_cmd(CMD_RELEASE, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_cmd(CMD_RELEASE, 16'd0, 8'd2, 16'd0);
        for (int k = 1; k <= 16; k++)
            send_cmd(CMD_ALLOC, 16'(k), 8'(k), 16'd0);
        for (int k = 2; k <= 16; k += 2)
            send_cmd(CMD_RELEASE, 16'd0, 8'(k), 16'd0);

        for (int ph = 0; ph < 9; ph++)
        begin
            write_policy(ph == 0 ? POL_BEST : ph == 1 ? POL_WORST
                : ph == 2 ? POL_NEXT : ph == 3 ? POL_FIRST : 2'($urandom));
            if (ph == 3)
            begin
                send_idle_pct = 87;
                recv_idle_pct = 15;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 7)
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            for (int n = 0; n < 190; n++)
                random_cmd();
        end

        req.valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (2 * MAP_ENTRIES + 20) @(posedge clk);
        $display("Covered %0d results over %0d policy settings, with stalls and a long hold-off.",
            results_seen, policy_writes);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* filelist.f */
design/vpa_pkg.sv
design/vpa_if.sv
design/vpa_datapath.sv
design/vpa_ctrl.sv
design/variable_partition_allocator.sv
verif/vpa_tb_if.sv
verif/vpa_checker.sv
verif/testbench.sv
